>>> design/tmce_pkg.sv
// ----------------------------------------------------------------------------
// Text console engine package
// Shared types, command codes and constants for the console datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tmce_pkg;

    localparam int POS_W     = 11;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 8;
    localparam int CURSOR_W  = 11;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_BKSP    = 8'h08;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_FG   = 4'd7;
    localparam logic [COLOR_W-1:0] RESET_BG   = 4'd0;
    localparam logic [ATTR_W-1:0]  RESET_ATTR = {RESET_BG, RESET_FG};

    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

    typedef enum logic [1:0] {
        OP_CHAR  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_TAB,
        CMD_BKSP,
        CMD_CLEAR,
        CMD_WRITE,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [CHAR_W-1:0]   ch;
        logic [POS_W-1:0]    pos;
        logic [ATTR_W-1:0]   attr;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_TAB,
        ST_SCROLL,
        ST_SCROLL_TAIL,
        ST_BLANK,
        ST_CLEAR,
        ST_READ,
        ST_FINISH
    } back_state_t;

endpackage

`default_nettype wire

>>> design/text_mode_console_engine.sv
// ----------------------------------------------------------------------------
// Text-mode console engine
// A COLS x ROWS character/attribute screen with a cursor, driven by items.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_ valid/ready channel; every item returns exactly one
//   result beat on the m_ channel with the cursor after the item and, for a
//   cell read, the cell's character and attribute (background high nibble).
//   The cfg_ channel writes fg_color (index 0) and bg_color (index 1); it is
//   always ready and must only be used while the block is idle.
//   The engine carries out one item at a time; a tab writes TAB_SPACES blanks
//   and a read waits on the registered read of the screen memory.
//   A scroll and a clear are both bound by the single write port of the
//   screen memory, which is swept one cell per cycle.
//   After reset the screen is filled with light gray spaces on black, during
//   which s_ready stays low.
//   A two-entry command queue sits between decode and execution, and the
//   result sits in an output register, so input beats keep being taken while
//   the receiver stalls until the queue and the engine are full.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_console_engine
    import tmce_pkg::*;
#(
    parameter int COLS       = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_op,
    input  wire logic [CHAR_W-1:0]    s_char_code,
    input  wire logic [POS_W-1:0]     s_position,
    input  wire logic [COLOR_W-1:0]   s_cell_fg,
    input  wire logic [COLOR_W-1:0]   s_cell_bg,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CURSOR_W-1:0]       m_cursor,
    output logic [CHAR_W-1:0]         m_read_char,
    output logic [ATTR_W-1:0]         m_read_attr
);

    logic init_done;
    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    tmce_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_char_code (s_char_code),
        .s_position  (s_position),
        .s_cell_fg   (s_cell_fg),
        .s_cell_bg   (s_cell_bg),
        .init_done   (init_done),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    tmce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    tmce_back #(
        .COLS       (COLS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_ready     (pop_ready),
        .q_cmd       (pop_cmd),
        .init_done   (init_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cursor    (m_cursor),
        .m_read_char (m_read_char),
        .m_read_attr (m_read_attr)
    );

endmodule

`default_nettype wire

>>> design/tmce_front.sv
// ----------------------------------------------------------------------------
// Console front end
// Holds the color registers, accepts input beats and decodes them into
// commands for the execution queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tmce_front
    import tmce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_op,
    input  wire logic [CHAR_W-1:0]    s_char_code,
    input  wire logic [POS_W-1:0]     s_position,
    input  wire logic [COLOR_W-1:0]   s_cell_fg,
    input  wire logic [COLOR_W-1:0]   s_cell_bg,
    input  wire logic                 init_done,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output cmd_t                      push_cmd
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CMP_W  = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic               in_range;

    assign cfg_ready = 1'b1;

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid) begin
            if (cfg_addr == CFG_FG_COLOR) begin
                fg_next = cfg_data;
            end else if (cfg_addr == CFG_BG_COLOR) begin
                bg_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end else begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    // Nothing is taken while the back end is still sweeping the screen after reset.
    assign s_ready    = push_ready && init_done;
    assign push_valid = s_valid && init_done;
    assign in_range   = CMP_W'(s_position) < CMP_W'(CELLS);

    always_comb begin
        push_cmd.ch   = s_char_code;
        push_cmd.pos  = s_position;
        push_cmd.attr = {bg_reg, fg_reg};
        push_cmd.kind = CMD_NOP;
        unique case (op_t'(s_op))
            OP_CHAR: begin
                unique case (s_char_code)
                    CHAR_NEWLINE: push_cmd.kind = CMD_NEWLINE;
                    CHAR_RETURN:  push_cmd.kind = CMD_RETURN;
                    CHAR_TAB:     push_cmd.kind = CMD_TAB;
                    CHAR_BKSP:    push_cmd.kind = CMD_BKSP;
                    default:      push_cmd.kind = CMD_PUT;
                endcase
            end
            OP_CLEAR: push_cmd.kind = CMD_CLEAR;
            OP_WRITE: begin
                push_cmd.attr = {s_cell_bg, s_cell_fg};
                push_cmd.kind = in_range ? CMD_WRITE : CMD_NOP;
            end
            OP_READ: push_cmd.kind = in_range ? CMD_READ : CMD_NOP;
            default: push_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

>>> design/tmce_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue that decouples the decoder from the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tmce_queue
    import tmce_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/tmce_back.sv
// ----------------------------------------------------------------------------
// Console execution engine
// Owns the screen memory and the cursor, carries out decoded commands,
// runs the scroll and clear sweeps and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmce_back
    import tmce_pkg::*;
#(
    parameter int COLS       = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire cmd_t                q_cmd,
    output logic                     init_done,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [CURSOR_W-1:0]      m_cursor,
    output logic [CHAR_W-1:0]        m_read_char,
    output logic [ATTR_W-1:0]        m_read_attr
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW   = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] TAIL_CELL  = ADDR_W'(CELLS - COLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] COPY_SKEW  = ADDR_W'(COLS + 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

    logic [CELL_W-1:0]   mem [CELLS];
    logic [CELL_W-1:0]   rdata_reg;

    back_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [TAB_W-1:0]    tab_left_reg, tab_left_next;
    logic [ATTR_W-1:0]   attr_reg, attr_next;
    logic [CHAR_W-1:0]   res_char_reg, res_char_next;
    logic [ATTR_W-1:0]   res_attr_reg, res_attr_next;
    logic                m_valid_reg, m_valid_next;
    logic [CURSOR_W-1:0] m_cursor_reg, m_cursor_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic [ATTR_W-1:0]   m_attr_reg, m_attr_next;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [CELL_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;

    // One-cell advance of the cursor, shared by ordinary characters and tabs.
    logic                at_end;
    logic [ADDR_W-1:0]   adv_cur;
    logic [COL_W-1:0]    adv_col;
    logic [ROW_W-1:0]    adv_row;
    logic [ADDR_W-1:0]   row_start;

    assign at_end    = (col_reg == COL_LAST) && (row_reg == ROW_LAST);
    assign row_start = cur_reg - ADDR_W'(col_reg);

    always_comb begin
        adv_cur = at_end ? LAST_ROW : cur_reg + ADDR_W'(1);
        adv_col = (col_reg == COL_LAST) ? '0 : col_reg + COL_W'(1);
        adv_row = (col_reg == COL_LAST && !at_end) ? row_reg + ROW_W'(1) : row_reg;
    end

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        cnt_next      = cnt_reg;
        tab_left_next = tab_left_reg;
        attr_next     = attr_reg;
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_cursor_next = m_cursor_reg;
        m_char_next   = m_char_reg;
        m_attr_next   = m_attr_reg;
        q_ready       = 1'b0;
        we            = 1'b0;
        waddr         = cnt_reg;
        wdata         = {BLANK_CHAR, attr_reg};
        raddr         = cnt_reg;

        unique case (state_reg)
            ST_INIT: begin
                we    = 1'b1;
                wdata = {BLANK_CHAR, RESET_ATTR};
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    attr_next     = q_cmd.attr;
                    res_char_next = '0;
                    res_attr_next = '0;
                    tab_left_next = '0;
                    state_next    = ST_FINISH;
                    unique case (q_cmd.kind)
                        CMD_PUT: begin
                            we       = 1'b1;
                            waddr    = cur_reg;
                            wdata    = {q_cmd.ch, q_cmd.attr};
                            cur_next = adv_cur;
                            col_next = adv_col;
                            row_next = adv_row;
                            if (at_end) begin
                                cnt_next   = COLS_A;
                                state_next = ST_SCROLL;
                            end
                        end
                        CMD_NEWLINE: begin
                            col_next = '0;
                            if (row_reg == ROW_LAST) begin
                                cur_next   = LAST_ROW;
                                cnt_next   = COLS_A;
                                state_next = ST_SCROLL;
                            end else begin
                                cur_next = row_start + COLS_A;
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                        CMD_RETURN: begin
                            cur_next = row_start;
                            col_next = '0;
                        end
                        CMD_TAB: begin
                            tab_left_next = TAB_W'(TAB_SPACES);
                            state_next    = ST_TAB;
                        end
                        CMD_BKSP: begin
                            // Backspace at the first cell leaves the screen and the cursor unchanged.
                            if (cur_reg != '0) begin
                                we       = 1'b1;
                                waddr    = cur_reg - ADDR_W'(1);
                                wdata    = {BLANK_CHAR, q_cmd.attr};
                                cur_next = cur_reg - ADDR_W'(1);
                                if (col_reg == '0) begin
                                    col_next = COL_LAST;
                                    row_next = row_reg - ROW_W'(1);
                                end else begin
                                    col_next = col_reg - COL_W'(1);
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            cur_next   = '0;
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_WRITE: begin
                            we    = 1'b1;
                            waddr = ADDR_W'(q_cmd.pos);
                            wdata = {q_cmd.ch, q_cmd.attr};
                        end
                        CMD_READ: begin
                            raddr      = ADDR_W'(q_cmd.pos);
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_TAB: begin
                we            = 1'b1;
                waddr         = cur_reg;
                wdata         = {BLANK_CHAR, attr_reg};
                cur_next      = adv_cur;
                col_next      = adv_col;
                row_next      = adv_row;
                tab_left_next = tab_left_reg - TAB_W'(1);
                if (at_end) begin
                    cnt_next   = COLS_A;
                    state_next = ST_SCROLL;
                end else if (tab_left_reg == TAB_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCROLL: begin
                // Read one row ahead and write back the cell read in the previous cycle.
                raddr = cnt_reg;
                if (cnt_reg != COLS_A) begin
                    we    = 1'b1;
                    waddr = cnt_reg - COPY_SKEW;
                    wdata = rdata_reg;
                end
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_SCROLL_TAIL;
                end
            end
            ST_SCROLL_TAIL: begin
                we         = 1'b1;
                waddr      = TAIL_CELL;
                wdata      = rdata_reg;
                cnt_next   = LAST_ROW;
                state_next = ST_BLANK;
            end
            ST_BLANK: begin
                we       = 1'b1;
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_CELL) begin
                    state_next = (tab_left_reg != '0) ? ST_TAB : ST_FINISH;
                end
            end
            ST_CLEAR: begin
                we       = 1'b1;
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ: begin
                res_char_next = rdata_reg[CELL_W-1:ATTR_W];
                res_attr_next = rdata_reg[ATTR_W-1:0];
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_cursor_next = CURSOR_W'(cur_reg);
                    m_char_next   = res_char_reg;
                    m_attr_next   = res_attr_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            cur_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= '0;
            tab_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            cnt_reg      <= cnt_next;
            tab_left_reg <= tab_left_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        attr_reg     <= attr_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        m_cursor_reg <= m_cursor_next;
        m_char_reg   <= m_char_next;
        m_attr_reg   <= m_attr_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign init_done   = (state_reg != ST_INIT);
    assign m_valid     = m_valid_reg;
    assign m_cursor    = m_cursor_reg;
    assign m_read_char = m_char_reg;
    assign m_read_attr = m_attr_reg;

endmodule

`default_nettype wire

>>> design/tmce_checker.sv
// ----------------------------------------------------------------------------
// Console engine port checker
// Watches the top-level ports for result ordering and cursor sanity.
// ----------------------------------------------------------------------------
`default_nettype none

module tmce_checker
    import tmce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [CURSOR_W-1:0] m_cursor,
    input wire logic [CHAR_W-1:0]   m_read_char,
    input wire logic [ATTR_W-1:0]   m_read_attr
);

    localparam int CELLS = COLS * ROWS;

    logic [3:0] pending_reg, pending_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (in_beat && !out_beat) begin
            pending_next = pending_reg + 4'd1;
        end else if (!in_beat && out_beat) begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 4'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Every result beat must answer an item that was taken earlier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 4'd0)
        else $error("result beat without an outstanding item");

    // Two queue slots, one command in execution and one output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 4'd4)
        else $error("more items in flight than the engine can hold");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_cursor) < CELLS)
        else $error("cursor beyond the screen");

    // The screen fill after reset keeps the input closed.
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block active right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor)
            && $stable(m_read_char) && $stable(m_read_attr))
        else $error("stalled result beat changed");

endmodule

bind text_mode_console_engine tmce_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tmce_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_cursor    (m_cursor),
    .m_read_char (m_read_char),
    .m_read_attr (m_read_attr)
);

`default_nettype wire
